[rtl/iwqr_pkg.sv]
// shared types and constants for the quota regulator
`default_nettype none
package iwqr_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = 6;
    localparam int CNT_W        = 7;
    localparam int SAMPLE_W     = 16;
    localparam int FACT_W       = 16;
    localparam int SUM_W        = 22;
    localparam int SQ_W         = 38;
    localparam int QUOTA_BITS   = 24;
    localparam int PROD_W       = QUOTA_BITS + FACT_W;
    localparam int PQ_W         = PROD_W - 12;
    localparam int SPREAD_W     = 21;
    localparam int NSQ_W        = CNT_W + SQ_W;
    localparam int SUM2_W       = 2 * SUM_W;
    localparam int NN_W         = 2 * CNT_W;
    localparam int REM_W        = NN_W + 1;
    localparam int DIVQ_W       = NSQ_W;
    localparam int MEAN_PAD     = DIVQ_W - SUM_W;
    localparam int SQRT_W       = DIVQ_W + 1;
    localparam int STEP_W       = 6;
    localparam int MEAN_STEPS   = SUM_W;
    localparam int VAR_STEPS    = DIVQ_W;
    localparam int SQRT_STEPS   = SQRT_W / 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREASE_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECREASE_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUOTA       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUOTA       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_FACTOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_ENABLE   = 3'd6;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_JUMP_HIGH = 3'd1,
        ACT_INCREASE  = 3'd2,
        ACT_DECREASE  = 3'd3,
        ACT_JUMP_LOW  = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_QMUL, ST_QUPD, ST_SQUARE, ST_SUM, ST_PROD,
        ST_MEANLD, ST_DIVM, ST_VARLD, ST_DIVV, ST_SQRTLD, ST_SQRT, ST_BAND,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic decide;
        logic qmul;
        logic qupd;
        logic square;
        logic sum_upd;
        logic prod;
        logic mean_ld;
        logic div_step;
        logic var_ld;
        logic sqrt_ld;
        logic sqrt_step;
        logic band;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/iwqr_ctrl.sv]
// sequencer for one item through the regulator datapath
`default_nettype none
module iwqr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  iwqr_pkg::t_sts     i_sts,
    output iwqr_pkg::t_cmd     o_cmd
);

    iwqr_pkg::t_state               r_state, n_state;
    logic [iwqr_pkg::STEP_W-1:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iwqr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            iwqr_pkg::ST_IDLE: begin
                // register writes go first, a sample waits behind them
                o_cfg_ready = i_rst_n;
                o_in_ready  = i_rst_n && !i_cfg_valid;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = iwqr_pkg::ST_DECIDE;
                end
            end
            iwqr_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = iwqr_pkg::ST_QMUL;
            end
            iwqr_pkg::ST_QMUL: begin
                o_cmd.qmul = 1'b1;
                n_state    = iwqr_pkg::ST_QUPD;
            end
            iwqr_pkg::ST_QUPD: begin
                o_cmd.qupd = 1'b1;
                n_state    = iwqr_pkg::ST_SQUARE;
            end
            iwqr_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = iwqr_pkg::ST_SUM;
            end
            iwqr_pkg::ST_SUM: begin
                o_cmd.sum_upd = 1'b1;
                n_state       = iwqr_pkg::ST_PROD;
            end
            iwqr_pkg::ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = iwqr_pkg::ST_MEANLD;
            end
            iwqr_pkg::ST_MEANLD: begin
                o_cmd.mean_ld = 1'b1;
                n_cnt         = iwqr_pkg::STEP_W'(iwqr_pkg::MEAN_STEPS - 1);
                n_state       = iwqr_pkg::ST_DIVM;
            end
            iwqr_pkg::ST_DIVM: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = iwqr_pkg::ST_VARLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            iwqr_pkg::ST_VARLD: begin
                o_cmd.var_ld = 1'b1;
                n_cnt        = iwqr_pkg::STEP_W'(iwqr_pkg::VAR_STEPS - 1);
                n_state      = iwqr_pkg::ST_DIVV;
            end
            iwqr_pkg::ST_DIVV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = iwqr_pkg::ST_SQRTLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            iwqr_pkg::ST_SQRTLD: begin
                o_cmd.sqrt_ld = 1'b1;
                n_cnt         = iwqr_pkg::STEP_W'(iwqr_pkg::SQRT_STEPS - 1);
                n_state       = iwqr_pkg::ST_SQRT;
            end
            iwqr_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = iwqr_pkg::ST_BAND;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            iwqr_pkg::ST_BAND: begin
                o_cmd.band = 1'b1;
                n_state    = iwqr_pkg::ST_COMMIT;
            end
            iwqr_pkg::ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = iwqr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iwqr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/iwqr_dp.sv]
// window store, running sums, divider, square root, quota and output register
`default_nettype none
module iwqr_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  iwqr_pkg::t_cmd                           i_cmd,
    output iwqr_pkg::t_sts                           o_sts,
    input  wire logic [iwqr_pkg::SAMPLE_W-1:0]       i_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [iwqr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [iwqr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [iwqr_pkg::QUOTA_BITS-1:0]          o_quota,
    output logic [2:0]                               o_action,
    output logic                                     o_refilling,
    output logic [iwqr_pkg::SAMPLE_W-1:0]            o_window_mean,
    output logic [iwqr_pkg::SAMPLE_W-1:0]            o_deviation
);

    localparam int QB  = iwqr_pkg::QUOTA_BITS;
    localparam int SW  = iwqr_pkg::SAMPLE_W;
    localparam int PQW = iwqr_pkg::PQ_W;

    // configuration
    logic [iwqr_pkg::CNT_W-1:0]   r_wlen;
    logic [iwqr_pkg::FACT_W-1:0]  r_inc, r_dec, r_spf;
    logic [23:0]                  r_minq, r_maxq;
    logic                         r_adj;

    // window state
    logic [SW-1:0]                r_mem [iwqr_pkg::WINDOW_DEPTH];
    logic [iwqr_pkg::PTR_W-1:0]   r_ptr;
    logic [iwqr_pkg::CNT_W-1:0]   r_fill;
    logic [iwqr_pkg::SUM_W-1:0]   r_sum;
    logic [iwqr_pkg::SQ_W-1:0]    r_sq;
    logic                         r_refill, r_started;
    logic [QB-1:0]                r_quota;
    logic [SW-1:0]                r_center;
    logic [iwqr_pkg::SPREAD_W-1:0] r_spread;
    logic                         r_ov;

    // per item working registers
    logic [SW-1:0]                r_sample, r_rd, r_mean, r_dev;
    iwqr_pkg::t_action            r_action;
    logic [iwqr_pkg::PROD_W-1:0]  r_prod;
    logic [2*SW-1:0]              r_sq_new, r_sq_old;
    logic [iwqr_pkg::CNT_W-1:0]   r_n;
    logic [iwqr_pkg::NSQ_W-1:0]   r_nsq, r_num;
    logic [iwqr_pkg::SUM2_W-1:0]  r_sum2;
    logic [iwqr_pkg::REM_W-1:0]   r_rem;
    logic [iwqr_pkg::DIVQ_W-1:0]  r_quo;
    logic [iwqr_pkg::NN_W-1:0]    r_dvs;
    logic [iwqr_pkg::SQRT_W-1:0]  r_sv, r_sres, r_sbit;
    logic [QB-1:0]                r_oq;
    logic [2:0]                   r_oact;
    logic                         r_orefill;
    logic [SW-1:0]                r_omean, r_odev;

    logic [iwqr_pkg::CNT_W-1:0]   w_len, w_fill_inc;
    logic [iwqr_pkg::PTR_W-1:0]   w_idx;
    logic signed [23:0]           w_x, w_c, w_hi2, w_hi1, w_lo1, w_lo2;
    iwqr_pkg::t_action            w_act;
    logic [PQW-1:0]               w_p, w_m;
    logic [QB-1:0]                w_qnew;
    logic [iwqr_pkg::REM_W-1:0]   w_t;
    logic                         w_ge;
    logic [iwqr_pkg::SQRT_W-1:0]  w_tr;
    logic [31:0]                  w_bprod;
    logic                         w_done;

    // effective window length, 0 acts as 1, values above 64 act as 64
    always_comb begin
        if (r_wlen == '0) begin
            w_len = iwqr_pkg::CNT_W'(1);
        end else if (r_wlen > iwqr_pkg::CNT_W'(iwqr_pkg::WINDOW_DEPTH)) begin
            w_len = iwqr_pkg::CNT_W'(iwqr_pkg::WINDOW_DEPTH);
        end else begin
            w_len = r_wlen;
        end
    end

    assign w_idx = ({1'b0, r_ptr} < w_len) ? r_ptr : '0;
    assign w_fill_inc = (r_fill != '1) ? r_fill + 1'b1 : r_fill;

    // band edges and action choice
    always_comb begin
        w_x   = $signed({8'b0, r_sample});
        w_c   = $signed({8'b0, r_center});
        w_hi1 = w_c + $signed({3'b0, r_spread});
        w_hi2 = w_hi1 + $signed({3'b0, r_spread});
        w_lo1 = w_c - $signed({3'b0, r_spread});
        w_lo2 = w_lo1 - $signed({3'b0, r_spread});
        w_act = iwqr_pkg::ACT_NONE;
        if (!r_refill && r_adj) begin
            if (w_x > w_hi2) begin
                w_act = iwqr_pkg::ACT_JUMP_HIGH;
            end else if (w_x >= w_c && w_x <= w_hi1) begin
                w_act = iwqr_pkg::ACT_INCREASE;
            end else if (w_x > w_lo2 && w_x <= w_lo1) begin
                w_act = iwqr_pkg::ACT_DECREASE;
            end else if (w_x < w_lo2) begin
                w_act = iwqr_pkg::ACT_JUMP_LOW;
            end
        end
    end

    // scaled quota, clamped, then saturated to the quota width
    always_comb begin
        w_p = r_prod[iwqr_pkg::PROD_W-1:12];
        if (r_action == iwqr_pkg::ACT_INCREASE) begin
            w_m = (w_p < PQW'(r_maxq)) ? w_p : PQW'(r_maxq);
        end else begin
            w_m = (w_p > PQW'(r_minq)) ? w_p : PQW'(r_minq);
        end
        w_qnew = (|w_m[PQW-1:QB]) ? '1 : w_m[QB-1:0];
    end

    // restoring divider and square root steps
    assign w_t  = {r_rem[iwqr_pkg::REM_W-2:0], r_quo[iwqr_pkg::DIVQ_W-1]};
    assign w_ge = (w_t >= {1'b0, r_dvs});
    assign w_tr = r_sres + r_sbit;

    assign w_bprod = 32'(r_spf) * 32'(r_dev);
    assign w_done  = r_refill && (r_fill >= w_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= iwqr_pkg::CNT_W'(8);
            r_inc  <= 16'd4505;
            r_dec  <= 16'd3686;
            r_minq <= 24'd10000;
            r_maxq <= 24'd100000;
            r_spf  <= 16'd4096;
            r_adj  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iwqr_pkg::CFG_WINDOW_LENGTH:   r_wlen <= i_cfg_data[iwqr_pkg::CNT_W-1:0];
                iwqr_pkg::CFG_INCREASE_FACTOR: r_inc  <= i_cfg_data[15:0];
                iwqr_pkg::CFG_DECREASE_FACTOR: r_dec  <= i_cfg_data[15:0];
                iwqr_pkg::CFG_MIN_QUOTA:       r_minq <= i_cfg_data;
                iwqr_pkg::CFG_MAX_QUOTA:       r_maxq <= i_cfg_data;
                iwqr_pkg::CFG_SPREAD_FACTOR:   r_spf  <= i_cfg_data[15:0];
                iwqr_pkg::CFG_ADJUST_ENABLE:   r_adj  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_refill  <= 1'b1;
            r_started <= 1'b0;
            r_quota   <= '0;
            r_center  <= '0;
            r_spread  <= '0;
            r_ov      <= 1'b0;
        end else begin
            // output register: loaded at commit, emptied when taken
            r_ov <= i_cmd.commit || (r_ov && !i_out_ready);
            if (i_cfg_we && i_cfg_index == iwqr_pkg::CFG_WINDOW_LENGTH) begin
                r_ptr    <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
                r_sq     <= '0;
                r_refill <= 1'b1;
            end
            if (i_cmd.accept && !r_started) begin
                r_quota   <= r_adj ? QB'(r_minq) : QB'(r_maxq);
                r_started <= 1'b1;
            end
            if (i_cmd.decide && (w_act == iwqr_pkg::ACT_JUMP_HIGH ||
                                 w_act == iwqr_pkg::ACT_JUMP_LOW)) begin
                r_quota  <= QB'(r_minq);
                r_ptr    <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
                r_sq     <= '0;
                r_refill <= 1'b1;
            end
            if (i_cmd.qupd && (r_action == iwqr_pkg::ACT_INCREASE ||
                               r_action == iwqr_pkg::ACT_DECREASE)) begin
                r_quota <= w_qnew;
            end
            if (i_cmd.sum_upd) begin
                if (!r_refill) begin
                    r_sum <= r_sum - iwqr_pkg::SUM_W'(r_rd) + iwqr_pkg::SUM_W'(r_sample);
                    r_sq  <= r_sq - iwqr_pkg::SQ_W'(r_sq_old) + iwqr_pkg::SQ_W'(r_sq_new);
                    r_ptr <= ({1'b0, w_idx} + 1'b1 >= w_len) ? '0 : w_idx + 1'b1;
                end else begin
                    r_sum  <= r_sum + iwqr_pkg::SUM_W'(r_sample);
                    r_sq   <= r_sq + iwqr_pkg::SQ_W'(r_sq_new);
                    r_fill <= w_fill_inc;
                end
            end
            if (i_cmd.commit) begin
                if (w_done) begin
                    r_refill <= 1'b0;
                    r_ptr    <= '0;
                    r_center <= r_mean;
                    r_spread <= iwqr_pkg::SPREAD_W'(w_bprod[31:12]);
                end
            end
        end
    end

    // window memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.qupd) begin
            r_rd <= r_mem[w_idx];
        end
        if (i_cmd.sum_upd) begin
            if (!r_refill) begin
                r_mem[w_idx] <= r_sample;
            end else if (r_fill < iwqr_pkg::CNT_W'(iwqr_pkg::WINDOW_DEPTH)) begin
                r_mem[r_fill[iwqr_pkg::PTR_W-1:0]] <= r_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.decide) begin
            r_action <= w_act;
        end
        if (i_cmd.qmul) begin
            r_prod <= iwqr_pkg::PROD_W'(r_quota) * iwqr_pkg::PROD_W'(
                (r_action == iwqr_pkg::ACT_INCREASE) ? r_inc : r_dec);
        end
        if (i_cmd.qupd) begin
            r_sq_new <= (2*SW)'(r_sample) * (2*SW)'(r_sample);
        end
        if (i_cmd.square) begin
            r_sq_old <= (2*SW)'(r_rd) * (2*SW)'(r_rd);
        end
        if (i_cmd.sum_upd) begin
            r_n <= r_refill ? w_fill_inc : w_len;
        end
        if (i_cmd.prod) begin
            r_nsq  <= iwqr_pkg::NSQ_W'(r_n) * iwqr_pkg::NSQ_W'(r_sq);
            r_sum2 <= iwqr_pkg::SUM2_W'(r_sum) * iwqr_pkg::SUM2_W'(r_sum);
        end
        if (i_cmd.mean_ld) begin
            r_num <= ({1'b0, r_sum2} < r_nsq) ? r_nsq - iwqr_pkg::NSQ_W'(r_sum2) : '0;
            r_quo <= {r_sum, {iwqr_pkg::MEAN_PAD{1'b0}}};
            r_rem <= '0;
            r_dvs <= iwqr_pkg::NN_W'(r_n);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_t - {1'b0, r_dvs} : w_t;
            r_quo <= {r_quo[iwqr_pkg::DIVQ_W-2:0], w_ge};
        end
        if (i_cmd.var_ld) begin
            r_mean <= (|r_quo[iwqr_pkg::SUM_W-1:SW]) ? '1 : r_quo[SW-1:0];
            r_quo  <= r_num;
            r_rem  <= '0;
            r_dvs  <= iwqr_pkg::NN_W'(r_n) * iwqr_pkg::NN_W'(r_n);
        end
        if (i_cmd.sqrt_ld) begin
            r_sv   <= {1'b0, r_quo};
            r_sres <= '0;
            r_sbit <= iwqr_pkg::SQRT_W'(1) << (iwqr_pkg::SQRT_W - 2);
        end
        if (i_cmd.sqrt_step) begin
            if (r_sv >= w_tr) begin
                r_sv   <= r_sv - w_tr;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
        if (i_cmd.band) begin
            r_dev <= (|r_sres[iwqr_pkg::SQRT_W-1:SW]) ? '1 : r_sres[SW-1:0];
        end
        if (i_cmd.commit) begin
            r_oq      <= r_quota;
            r_oact    <= r_action;
            r_orefill <= r_refill && !w_done;
            r_omean   <= r_mean;
            r_odev    <= r_dev;
        end
    end

    assign o_sts.out_free = !r_ov || i_out_ready;
    assign o_out_valid    = r_ov;
    assign o_quota        = r_oq;
    assign o_action       = r_oact;
    assign o_refilling    = r_orefill;
    assign o_window_mean  = r_omean;
    assign o_deviation    = r_odev;

endmodule
`default_nettype wire

[rtl/ipc_window_quota_regulator.sv]
// top level of the sliding-window quota regulator
`default_nettype none
// Takes one Q4.12 throughput sample per item and returns one result item:
// the quota in force, the action taken, the refill status, and the window
// mean and standard deviation. Each item runs through one sequence of
// steps: the band decision, the quota multiply and the window update
// (one memory read, one write), then a one-bit-per-cycle restoring divider
// used twice (22 steps for the mean, 45 for the variance) and a 23-step
// integer square root, each after a load step, then the band and commit
// steps; the sample itself is taken in the idle state. The divider and
// square root set the rate. One item is worked on at a time; the next
// sample is taken once the result has moved into the output register, so
// a result still waiting there holds the next item at its last step. The
// window store powers up unwritten and is filled before it is read.
// Configuration writes are taken only while the block is idle and go
// ahead of a waiting sample; writing the window length restarts the fill.
module ipc_window_quota_regulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [23:0] quota, [26:24] action,
                                             // [27] refilling, [43:28] window_mean,
                                             // [59:44] deviation, rest zero
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    iwqr_pkg::t_cmd   w_cmd;
    iwqr_pkg::t_sts   w_sts;
    logic [23:0]      w_quota;
    logic [2:0]       w_action;
    logic             w_refilling;
    logic [15:0]      w_mean, w_dev;
    logic             w_cfg_we;

    // registers are written only between items
    assign w_cfg_we = i_cfg_valid & o_cfg_ready;

    iwqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    iwqr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_sample      (s_axis_tdata),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_quota       (w_quota),
        .o_action      (w_action),
        .o_refilling   (w_refilling),
        .o_window_mean (w_mean),
        .o_deviation   (w_dev)
    );

    // pack result item, lowest field first
    assign m_axis_tdata = {4'b0, w_dev, w_mean, w_refilling, w_action, w_quota};

    // one item at a time: no second sample right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample taken while previous item still in work");

    // action code within the defined set
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[26:24] <= 3'd4))
        else $error("undefined action code on output");

    // a result cannot appear in the cycle right after a sample is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result produced before computation finished");

endmodule
`default_nettype wire
